// File: src/chorus_pkg.sv
// ----------------------------------------------------------------------------
// chorus_pkg
// Shared types, constants and the sine table of the chorus unit.
// ----------------------------------------------------------------------------
package chorus_pkg;

    // delay line geometry and sample format
    localparam int LINE_DEPTH  = 4096;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int SAMPLE_BITS = 24;
    localparam int PERIOD_W    = 20;
    localparam int DEPTH_W     = 12;
    localparam int PCT_W       = 7;

    // lfo and shared divider
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
    localparam int MAG_W       = 15;
    localparam int QUOT_W      = 13;
    localparam int REM_W       = PERIOD_W;
    localparam int NUM_W       = QUOT_W + REM_W;
    localparam int CNT_W       = 4;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // divide by one hundred as a reciprocal multiply
    localparam int PROD_MAG_W  = 30;
    localparam int RECIP_SHIFT = 38;
    localparam logic [31:0] RECIP_100 = 32'd2748779070;

    // configuration port
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRY      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 8'd7;

    typedef struct packed {
        logic [DEPTH_W-1:0]  delay;
        logic [DEPTH_W-1:0]  depth;
        logic [PERIOD_W-1:0] period;
        logic                sine;
        logic [PCT_W-1:0]    dry;
        logic [PCT_W-1:0]    wet;
        logic [PCT_W-1:0]    feedback;
        logic [1:0]          polarity;
    } cfg_t;

    // one classified item between front and back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
        logic [ADDR_W-1:0]             tap;
        logic [ADDR_W-1:0]             wp;
    } link_t;

    typedef logic [MAG_W-1:0] sine_rom_t [SINE_DEPTH];

    // q15 magnitude of one sine entry, quarter wave taylor series
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned idx);
        longint unsigned u;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned term;
        longint unsigned mag;
        longint          sum;
        u = 64'(4 * (idx % SINE_DEPTH));
        q = u / SINE_DEPTH;
        r = u % SINE_DEPTH;
        if (q[0])
        begin
            r = 64'(SINE_DEPTH) - r;
        end
        x    = (r * HALF_PI_Q30) / SINE_DEPTH;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        mag = (64'(sum) + 64'd16384) >> 15;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        return mag[MAG_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            rom[i] = sine_mag(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // clamp a widened sum to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAMPLE_BITS+1:0] v
    );
        logic signed [SAMPLE_BITS+1:0] hi;
        logic signed [SAMPLE_BITS+1:0] lo;
        hi = (SAMPLE_BITS+2)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        lo = -hi - (SAMPLE_BITS+2)'(1);
        if (v > hi)
        begin
            return hi[SAMPLE_BITS-1:0];
        end
        else if (v < lo)
        begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

// File: src/chorus_front.sv
// ----------------------------------------------------------------------------
// chorus_front
// Accepts samples, runs the lfo and works out the delay line tap address.
// ----------------------------------------------------------------------------
module chorus_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      push,
    output logic                                      full,
    input  logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                      block_end,
    input  chorus_pkg::cfg_t                          cfg,
    input  logic                                      phase_clear,
    input  logic                                      link_full,
    output logic                                      link_push,
    output chorus_pkg::link_t                         link_data
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIV  = 5'b00010,
        F_LOOK = 5'b00100,
        F_MUL  = 5'b01000,
        F_SEND = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [chorus_pkg::ADDR_W-1:0]      wp_reg;
    logic [chorus_pkg::PERIOD_W-1:0]    phase_reg;
    logic signed [chorus_pkg::SAMPLE_BITS-1:0] x_reg;
    logic                               be_reg;
    logic [chorus_pkg::ADDR_W-1:0]      wp_item_reg;
    logic [chorus_pkg::REM_W-1:0]       rem_reg;
    logic [chorus_pkg::QUOT_W-1:0]      low_reg;
    logic [chorus_pkg::QUOT_W-1:0]      quot_reg;
    logic [chorus_pkg::CNT_W-1:0]       cnt_reg;
    logic [chorus_pkg::MAG_W-1:0]       mag_reg;
    logic                               neg_reg;
    logic [chorus_pkg::DEPTH_W-1:0]     off_reg;

    logic                               accept;
    logic [chorus_pkg::PERIOD_W-1:0]    period_eff;
    logic [chorus_pkg::PERIOD_W-1:0]    tri_k;
    logic [chorus_pkg::NUM_W-1:0]       num;
    logic [chorus_pkg::PERIOD_W:0]      phase_inc;
    logic [chorus_pkg::REM_W:0]         trial;
    logic                               ge;
    logic [chorus_pkg::REM_W:0]         trial_sub;
    logic [chorus_pkg::ADDR_W-1:0]      base;
    logic [chorus_pkg::ADDR_W-1:0]      tap;
    logic [27:0]                        off_prod;

    assign full   = (state_reg != F_IDLE);
    assign accept = push && (state_reg == F_IDLE);

    // lfo numerator for the shared divider
    always_comb
    begin
        period_eff = (cfg.period == '0) ? chorus_pkg::PERIOD_W'(1) : cfg.period;
        tri_k      = (phase_reg < (period_eff >> 1)) ? phase_reg : (period_eff - phase_reg);
        if (cfg.sine)
        begin
            num = chorus_pkg::NUM_W'({phase_reg, {chorus_pkg::SINE_IDX_W{1'b0}}});
        end
        else
        begin
            num = chorus_pkg::NUM_W'(cfg.depth) * chorus_pkg::NUM_W'({tri_k, 1'b0});
        end
        phase_inc = {1'b0, phase_reg} + (chorus_pkg::PERIOD_W+1)'(1);
    end

    // one quotient bit a cycle
    always_comb
    begin
        trial     = {rem_reg, low_reg[chorus_pkg::QUOT_W-1]};
        ge        = (trial >= {1'b0, period_eff});
        trial_sub = trial - {1'b0, period_eff};
        off_prod  = 28'(cfg.depth) * 28'(mag_reg) + 28'd16384;
    end

    // tap address
    always_comb
    begin
        base = wp_item_reg - cfg.delay;
        if (cfg.sine)
        begin
            base = base - chorus_pkg::ADDR_W'(cfg.depth >> 1);
            tap  = neg_reg ? (base + off_reg) : (base - off_reg);
        end
        else
        begin
            tap = base - quot_reg[chorus_pkg::ADDR_W-1:0];
        end
    end

    assign link_push        = (state_reg == F_SEND) && !link_full;
    assign link_data.sample    = x_reg;
    assign link_data.block_end = be_reg;
    assign link_data.tap       = tap;
    assign link_data.wp        = wp_item_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == chorus_pkg::CNT_W'(chorus_pkg::QUOT_W - 1))
                begin
                    state_next = cfg.sine ? F_LOOK : F_SEND;
                end
            end
            F_LOOK:
            begin
                state_next = F_MUL;
            end
            F_MUL:
            begin
                state_next = F_SEND;
            end
            F_SEND:
            begin
                if (!link_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control and lfo state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wp_reg    <= '0;
            phase_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (phase_clear)
            begin
                phase_reg <= '0;
            end
            else if (accept)
            begin
                phase_reg <= (phase_inc == {1'b0, period_eff}) ? '0
                                                               : phase_inc[chorus_pkg::PERIOD_W-1:0];
            end
            if (accept)
            begin
                wp_reg  <= wp_reg + chorus_pkg::ADDR_W'(1);
                cnt_reg <= '0;
            end
            else if (state_reg == F_DIV)
            begin
                cnt_reg <= cnt_reg + chorus_pkg::CNT_W'(1);
            end
        end
    end

    // item payload and datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg       <= sample_in;
            be_reg      <= block_end;
            wp_item_reg <= wp_reg;
            rem_reg     <= num[chorus_pkg::NUM_W-1:chorus_pkg::QUOT_W];
            low_reg     <= num[chorus_pkg::QUOT_W-1:0];
            quot_reg    <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            rem_reg  <= ge ? trial_sub[chorus_pkg::REM_W-1:0] : trial[chorus_pkg::REM_W-1:0];
            low_reg  <= {low_reg[chorus_pkg::QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[chorus_pkg::QUOT_W-2:0], ge};
        end
        if (state_reg == F_LOOK)
        begin
            mag_reg <= chorus_pkg::SINE_ROM[quot_reg[chorus_pkg::SINE_IDX_W-1:0]];
            neg_reg <= quot_reg[chorus_pkg::SINE_IDX_W-1];
        end
        if (state_reg == F_MUL)
        begin
            off_reg <= off_prod[26:15];
        end
    end

endmodule

// File: src/chorus_link_q.sv
// ----------------------------------------------------------------------------
// chorus_link_q
// Two entry queue that carries classified items from front to back.
// ----------------------------------------------------------------------------
module chorus_link_q (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  chorus_pkg::link_t wdata,
    input  logic              pop,
    output logic              empty,
    output chorus_pkg::link_t rdata
);

    chorus_pkg::link_t data_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/chorus_back.sv
// ----------------------------------------------------------------------------
// chorus_back
// Reads the tap, mixes dry and wet, writes the delay line and holds the result.
// ----------------------------------------------------------------------------
module chorus_back (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  chorus_pkg::cfg_t                          cfg,
    input  logic                                      link_empty,
    input  chorus_pkg::link_t                         link_data,
    output logic                                      link_pop,
    output logic                                      empty,
    input  logic                                      pop,
    output logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                      block_end_out
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_READ  = 5'b00010,
        B_MUL   = 5'b00100,
        B_SCALE = 5'b01000,
        B_DONE  = 5'b10000
    } back_state_t;

    localparam int SW = chorus_pkg::SAMPLE_BITS;
    localparam int MW = chorus_pkg::PROD_MAG_W;

    back_state_t state_reg, state_next;

    logic signed [SW-1:0]  mem [chorus_pkg::LINE_DEPTH];
    chorus_pkg::link_t     cur_reg;
    logic signed [SW-1:0]  rd_data_reg;
    logic                  tap_ok_reg;
    logic                  filled_reg;
    logic [MW-1:0]         dry_mag_reg, wet_mag_reg, fb_mag_reg;
    logic                  dry_neg_reg, wet_neg_reg, fb_neg_reg;
    logic [SW-1:0]         dry_q_reg, wet_q_reg, fb_q_reg;
    logic                  out_valid_reg;
    logic signed [SW-1:0]  out_sample_reg;
    logic                  out_be_reg;

    logic signed [SW-1:0]  d_eff;
    logic signed [31:0]    p_dry, p_wet, p_fb;
    logic [61:0]           s_dry, s_wet, s_fb;
    logic signed [SW:0]    dry_s, wet_s, fb_s;
    logic signed [SW+1:0]  y_sum, st_sum;
    logic signed [SW-1:0]  stored;
    logic                  out_free;
    logic                  finish;

    assign out_free = !out_valid_reg || pop;
    assign finish   = (state_reg == B_DONE) && out_free;
    assign link_pop = (state_reg == B_IDLE) && !link_empty;
    assign empty    = !out_valid_reg;
    assign sample_out    = out_sample_reg;
    assign block_end_out = out_be_reg;

    // percent products, then divide by one hundred toward zero
    always_comb
    begin
        d_eff = tap_ok_reg ? rd_data_reg : '0;
        p_dry = $signed({1'b0, cfg.dry}) * cur_reg.sample;
        p_wet = $signed({1'b0, cfg.wet}) * d_eff;
        p_fb  = $signed({1'b0, cfg.feedback}) * d_eff;
        s_dry = 62'(dry_mag_reg) * 62'(chorus_pkg::RECIP_100);
        s_wet = 62'(wet_mag_reg) * 62'(chorus_pkg::RECIP_100);
        s_fb  = 62'(fb_mag_reg) * 62'(chorus_pkg::RECIP_100);
    end

    // mix and saturate
    always_comb
    begin
        dry_s = dry_neg_reg ? -$signed({1'b0, dry_q_reg}) : $signed({1'b0, dry_q_reg});
        wet_s = wet_neg_reg ? -$signed({1'b0, wet_q_reg}) : $signed({1'b0, wet_q_reg});
        fb_s  = fb_neg_reg ? -$signed({1'b0, fb_q_reg}) : $signed({1'b0, fb_q_reg});
        y_sum = cfg.polarity[0] ? ((SW+2)'(dry_s) - (SW+2)'(wet_s))
                                : ((SW+2)'(dry_s) + (SW+2)'(wet_s));
        st_sum = cfg.polarity[1] ? ((SW+2)'(cur_reg.sample) - (SW+2)'(fb_s))
                                 : ((SW+2)'(cur_reg.sample) + (SW+2)'(fb_s));
        stored = chorus_pkg::sat_sample(st_sum);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!link_empty)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:  state_next = B_MUL;
            B_MUL:   state_next = B_SCALE;
            B_SCALE: state_next = B_DONE;
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control state and result holding flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                if (cur_reg.wp == chorus_pkg::ADDR_W'(chorus_pkg::LINE_DEPTH - 1))
                begin
                    filled_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // delay line memory, entries beyond the fill count read as zero
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            mem[cur_reg.wp] <= stored;
        end
        rd_data_reg <= mem[cur_reg.tap];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (link_pop)
        begin
            cur_reg <= link_data;
        end
        if (state_reg == B_READ)
        begin
            tap_ok_reg <= filled_reg || (cur_reg.tap < cur_reg.wp);
        end
        if (state_reg == B_MUL)
        begin
            dry_neg_reg <= p_dry[31];
            wet_neg_reg <= p_wet[31];
            fb_neg_reg  <= p_fb[31];
            dry_mag_reg <= p_dry[31] ? MW'(-p_dry) : p_dry[MW-1:0];
            wet_mag_reg <= p_wet[31] ? MW'(-p_wet) : p_wet[MW-1:0];
            fb_mag_reg  <= p_fb[31] ? MW'(-p_fb) : p_fb[MW-1:0];
        end
        if (state_reg == B_SCALE)
        begin
            dry_q_reg <= s_dry[chorus_pkg::RECIP_SHIFT +: SW];
            wet_q_reg <= s_wet[chorus_pkg::RECIP_SHIFT +: SW];
            fb_q_reg  <= s_fb[chorus_pkg::RECIP_SHIFT +: SW];
        end
        if (finish)
        begin
            out_sample_reg <= chorus_pkg::sat_sample(y_sum);
            out_be_reg     <= cur_reg.block_end;
        end
    end

endmodule

// File: src/lfo_modulated_delay_chorus_unit.sv
// ----------------------------------------------------------------------------
// lfo_modulated_delay_chorus_unit
// Chorus effect: a 4096 sample delay line read at an lfo modulated tap.
// ----------------------------------------------------------------------------
// One sample in, one mixed sample out. The front part takes one sample at a
// time and holds off the next until the current one is in the queue: the tap
// offset comes from a one bit per cycle divider plus, for the sine, a table
// read and a depth multiply. The back part takes each sample through these
// steps (memory read, percent multiply, reciprocal scale, write back), and a
// two entry queue between the parts lets both run at once. Results wait in an
// output register; there is no clearing pass after reset, unwritten delay line
// entries read as zero. Configuration writes are always ready and take effect
// at once; a write to the lfo period restarts the lfo.
// ----------------------------------------------------------------------------
module lfo_modulated_delay_chorus_unit (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      push,
    output logic                                      full,
    input  logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                      block_end,
    output logic                                      empty,
    input  logic                                      pop,
    output logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                      block_end_out,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [chorus_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [chorus_pkg::CFG_DATA_W-1:0]         cfg_data
);

    chorus_pkg::cfg_t  cfg_reg;
    logic              cfg_wr;
    logic              phase_clear;
    logic              link_push, link_full, link_pop, link_empty;
    chorus_pkg::link_t link_wdata, link_rdata;

    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid && cfg_ready;
    assign phase_clear = cfg_wr && (cfg_index == chorus_pkg::REG_PERIOD);

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay    <= 12'd441;
            cfg_reg.depth    <= 12'd2646;
            cfg_reg.period   <= 20'd55125;
            cfg_reg.sine     <= 1'b0;
            cfg_reg.dry      <= 7'd75;
            cfg_reg.wet      <= 7'd80;
            cfg_reg.feedback <= 7'd0;
            cfg_reg.polarity <= 2'd1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                chorus_pkg::REG_DELAY:    cfg_reg.delay    <= cfg_data[11:0];
                chorus_pkg::REG_DEPTH:    cfg_reg.depth    <= cfg_data[11:0];
                chorus_pkg::REG_PERIOD:   cfg_reg.period   <= cfg_data[19:0];
                chorus_pkg::REG_WAVE:     cfg_reg.sine     <= cfg_data[0];
                chorus_pkg::REG_DRY:      cfg_reg.dry      <= cfg_data[6:0];
                chorus_pkg::REG_WET:      cfg_reg.wet      <= cfg_data[6:0];
                chorus_pkg::REG_FEEDBACK: cfg_reg.feedback <= cfg_data[6:0];
                chorus_pkg::REG_POLARITY: cfg_reg.polarity <= cfg_data[1:0];
                default:                  cfg_reg          <= cfg_reg;
            endcase
        end
    end

    chorus_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_in   (sample_in),
        .block_end   (block_end),
        .cfg         (cfg_reg),
        .phase_clear (phase_clear),
        .link_full   (link_full),
        .link_push   (link_push),
        .link_data   (link_wdata)
    );

    chorus_link_q u_link (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (link_push),
        .full  (link_full),
        .wdata (link_wdata),
        .pop   (link_pop),
        .empty (link_empty),
        .rdata (link_rdata)
    );

    chorus_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .link_empty    (link_empty),
        .link_data     (link_rdata),
        .link_pop      (link_pop),
        .empty         (empty),
        .pop           (pop),
        .sample_out    (sample_out),
        .block_end_out (block_end_out)
    );

endmodule

// File: src/chorus_checker.sv
// ----------------------------------------------------------------------------
// chorus_port_checks
// Port level checks of the chorus unit, bound to the top level.
// ----------------------------------------------------------------------------
module chorus_port_checks (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      push,
    input logic                                      full,
    input logic                                      empty,
    input logic                                      pop,
    input logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_out,
    input logic                                      block_end_out,
    input logic                                      cfg_ready
);

    // a waiting result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sample_out) && $stable(block_end_out)))
        else $error("result changed while waiting");

    // front takes one sample and then works on it
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("input not closed after accept");

    // an idle front stays open until a beat arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("input closed without a beat");

    // configuration port never stalls
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");

endmodule

bind lfo_modulated_delay_chorus_unit chorus_port_checks u_chk (.*);

// File: test/chorus_checker.sv
// ----------------------------------------------------------------------------
// chorus_checker
// Watches the sample, result and register channels of the chorus unit, keeps
// its own copy of the delay line, pointer, lfo phase and registers, works out
// the mixed sample for every accepted input beat and compares it with the
// oldest waiting result.
// ----------------------------------------------------------------------------
module chorus_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      push,
    input  logic                                      full,
    input  logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                      block_end,
    input  logic                                      empty,
    input  logic                                      pop,
    input  logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic                                      block_end_out,
    input  logic                                      cfg_valid,
    input  logic                                      cfg_ready,
    input  logic [chorus_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [chorus_pkg::CFG_DATA_W-1:0]         cfg_data,
    output int                                        errors,
    output int                                        pending,
    output int                                        results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [chorus_pkg::SAMPLE_BITS-1:0] mix;
        logic                                      marker;
    } mix_beat_t;

    mix_beat_t                                 mix_queue[$];
    logic signed [chorus_pkg::SAMPLE_BITS-1:0] line_mem [chorus_pkg::LINE_DEPTH];
    logic [chorus_pkg::ADDR_W-1:0]             wr_ptr;
    logic [chorus_pkg::PERIOD_W-1:0]           phase_acc;
    logic [chorus_pkg::DEPTH_W-1:0]            base_delay;
    logic [chorus_pkg::DEPTH_W-1:0]            mod_depth;
    logic [chorus_pkg::PERIOD_W-1:0]           period_reg;
    logic                                      use_sine;
    logic [chorus_pkg::PCT_W-1:0]              dry_pct;
    logic [chorus_pkg::PCT_W-1:0]              wet_pct;
    logic [chorus_pkg::PCT_W-1:0]              fb_pct;
    logic [1:0]                                pol;

    // q15 sine magnitude by quarter-wave reduction and a truncating series
    function automatic longint unsigned sine_q15(input int unsigned slot, output bit negative);
        longint unsigned quad;
        longint unsigned frac;
        longint unsigned ang;
        longint unsigned term;
        longint unsigned q15;
        longint          acc;
        quad = (4 * slot) / chorus_pkg::SINE_DEPTH;
        frac = (4 * slot) % chorus_pkg::SINE_DEPTH;
        if (quad[0])
        begin
            frac = chorus_pkg::SINE_DEPTH - frac;
        end
        ang  = frac * chorus_pkg::HALF_PI_Q30 / chorus_pkg::SINE_DEPTH;
        term = ang;
        acc  = longint'(ang);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((((term * ang) >> 30) * ang) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        q15 = (longint'(acc) + 16384) >> 15;
        if (q15 > 32767)
        begin
            q15 = 32767;
        end
        negative = (quad >= 2);
        return q15;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > 8388607)
        begin
            return 8388607;
        end
        if (v < -8388608)
        begin
            return -8388608;
        end
        return v;
    endfunction

    // one sample through the chorus: returns the mixed sample, updates state
    function automatic logic signed [chorus_pkg::SAMPLE_BITS-1:0] mix_sample(
        input logic signed [chorus_pkg::SAMPLE_BITS-1:0] x
    );
        longint unsigned per;
        longint unsigned ph;
        longint unsigned k;
        longint unsigned mag;
        longint          offs;
        longint          pos;
        longint          tapped;
        longint          wet_term;
        longint          fb_term;
        longint          y;
        bit              neg;
        per = (period_reg == 0) ? 1 : period_reg;
        ph  = phase_acc % per;
        if (use_sine)
        begin
            mag  = sine_q15(int'(ph * chorus_pkg::SINE_DEPTH / per), neg);
            offs = longint'((longint'(mod_depth) * mag + 16384) >> 15);
            if (neg)
            begin
                offs = -offs;
            end
            pos = longint'(wr_ptr) - longint'(base_delay) - longint'(mod_depth / 2) - offs;
        end
        else
        begin
            k   = (ph < per / 2) ? ph : per - ph;
            pos = longint'(wr_ptr) - longint'(base_delay)
                  - longint'(longint'(mod_depth) * 2 * k / per);
        end
        tapped   = line_mem[pos & (chorus_pkg::LINE_DEPTH - 1)];
        wet_term = longint'(wet_pct) * tapped / 100;
        fb_term  = longint'(fb_pct) * tapped / 100;
        y = longint'(dry_pct) * longint'(x) / 100;
        y = pol[0] ? y - wet_term : y + wet_term;
        line_mem[wr_ptr] = chorus_pkg::SAMPLE_BITS'(clamp24(pol[1] ? x - fb_term
                                                                    : x + fb_term));
        wr_ptr    = wr_ptr + 1'b1;
        phase_acc = chorus_pkg::PERIOD_W'((ph + 1) % per);
        return chorus_pkg::SAMPLE_BITS'(clamp24(y));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // watch all three channels on each edge
    always @(posedge clk or negedge rst_n)
    begin
        mix_beat_t exp_beat;
        if (!rst_n)
        begin
            foreach (line_mem[i]) line_mem[i] = '0;
            mix_queue.delete();
            wr_ptr       = '0;
            phase_acc    = '0;
            base_delay   = 12'd441;
            mod_depth    = 12'd2646;
            period_reg   = 20'd55125;
            use_sine     = 1'b0;
            dry_pct      = 7'd75;
            wet_pct      = 7'd80;
            fb_pct       = 7'd0;
            pol          = 2'd1;
            errors       = 0;
            results_seen = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    chorus_pkg::REG_DELAY:    base_delay = cfg_data[chorus_pkg::DEPTH_W-1:0];
                    chorus_pkg::REG_DEPTH:    mod_depth  = cfg_data[chorus_pkg::DEPTH_W-1:0];
                    chorus_pkg::REG_PERIOD:
                    begin
                        period_reg = cfg_data[chorus_pkg::PERIOD_W-1:0];
                        phase_acc  = '0;
                    end
                    chorus_pkg::REG_WAVE:     use_sine = cfg_data[0];
                    chorus_pkg::REG_DRY:      dry_pct  = cfg_data[chorus_pkg::PCT_W-1:0];
                    chorus_pkg::REG_WET:      wet_pct  = cfg_data[chorus_pkg::PCT_W-1:0];
                    chorus_pkg::REG_FEEDBACK: fb_pct   = cfg_data[chorus_pkg::PCT_W-1:0];
                    chorus_pkg::REG_POLARITY: pol      = cfg_data[1:0];
                    default: ;
                endcase
            end
            // input beat
            if (push && !full)
            begin
                exp_beat.mix    = mix_sample(sample_in);
                exp_beat.marker = block_end;
                mix_queue.push_back(exp_beat);
            end
            // result beat
            if (pop && !empty)
            begin
                results_seen++;
                if (mix_queue.size() == 0)
                begin
                    $display("%0t ns result beat with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    exp_beat = mix_queue.pop_front();
                    if (sample_out !== exp_beat.mix)
                    begin
                        report_mismatch("sample_out", sample_out, exp_beat.mix);
                    end
                    if (block_end_out !== exp_beat.marker)
                    begin
                        report_mismatch("block_end_out", block_end_out, exp_beat.marker);
                    end
                end
            end
        end
        pending = mix_queue.size();
    end

endmodule

// File: test/lfo_modulated_delay_chorus_unit_tb.sv
// ----------------------------------------------------------------------------
// lfo_modulated_delay_chorus_unit_tb
// Drives samples and register settings into the chorus unit with random gaps
// and stalls; the checker beside the block predicts every mixed sample.
// ----------------------------------------------------------------------------
module lfo_modulated_delay_chorus_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                                      clk;
    logic                                      rst_n;
    logic                                      push;
    logic                                      full;
    logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                      block_end;
    logic                                      empty;
    logic                                      pop;
    logic signed [chorus_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                      block_end_out;
    logic                                      cfg_valid;
    logic                                      cfg_ready;
    logic [chorus_pkg::CFG_IDX_W-1:0]          cfg_index;
    logic [chorus_pkg::CFG_DATA_W-1:0]         cfg_data;
    int                                        errors;
    int                                        pending;
    int                                        results_seen;

    bit  sender_idles;
    bit  receiver_idles;
    bit  long_hold_req;
    int  samples_sent;
    int  reg_writes;
    int  sine_phases;

    lfo_modulated_delay_chorus_unit i_dut (.*);

    chorus_checker i_checker (.*);

    // clock
    initial
    begin
        clk = 1'b0;
    end
    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #4000000;
        $display("[lfo_modulated_delay_chorus_unit] ERROR");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [chorus_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'sh000000;
            3: return 24'shFFFFFF;
            default: return chorus_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // receiver: random pops, long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 400;
                pop <= 1'b0;
            end
            else if (!receiver_idles)
            begin
                pop <= 1'b1;
            end
            else
            begin
                hold_left = (gap_len() > 20) ? $urandom_range(30, 120) : 0;
                pop <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // one sample beat; push stays high until a gap is wanted
    task automatic send_sample(input logic signed [chorus_pkg::SAMPLE_BITS-1:0] s,
                               input logic marker);
        int gap;
        gap = sender_idles ? gap_len() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        sample_in <= s;
        block_end <= marker;
        @(posedge clk);
        while (full) @(posedge clk);
        samples_sent++;
    endtask

    // block is idle once every expected result is back
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [chorus_pkg::CFG_IDX_W-1:0] idx, input int val);
        logic [chorus_pkg::CFG_DATA_W-1:0] noise;
        noise = chorus_pkg::CFG_DATA_W'($urandom);
        // upper bits beyond the field are don't-care, so fill them
        case (idx)
            chorus_pkg::REG_PERIOD: noise = '0;
            chorus_pkg::REG_DELAY, chorus_pkg::REG_DEPTH:
                noise[chorus_pkg::DEPTH_W-1:0] = '0;
            chorus_pkg::REG_WAVE: noise[0] = 1'b0;
            chorus_pkg::REG_POLARITY: noise[1:0] = '0;
            default: noise[chorus_pkg::PCT_W-1:0] = '0;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= chorus_pkg::CFG_DATA_W'(val) | noise;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 100;
            2: return 127;
            3: return $urandom_range(101, 127);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    function automatic int pick_len12();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int pick_period();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 1048575;
            4, 5: return $urandom_range(65, 6000);
            default: return $urandom_range(3, 64);
        endcase
    endfunction

    task automatic random_settings();
        write_reg(chorus_pkg::REG_DELAY, pick_len12());
        write_reg(chorus_pkg::REG_DEPTH, pick_len12());
        write_reg(chorus_pkg::REG_PERIOD, pick_period());
        write_reg(chorus_pkg::REG_WAVE, $urandom_range(0, 1));
        write_reg(chorus_pkg::REG_DRY, pick_pct());
        write_reg(chorus_pkg::REG_WET, pick_pct());
        write_reg(chorus_pkg::REG_FEEDBACK, pick_pct());
        write_reg(chorus_pkg::REG_POLARITY, $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(8'($urandom_range(8, 255)), int'(chorus_pkg::CFG_DATA_W'($urandom)));
        end
    endtask

    // stimulus
    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        sample_in      = '0;
        block_end      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        long_hold_req  = 1'b0;
        samples_sent   = 0;
        reg_writes     = 0;
        sine_phases    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, sample extremes and markers
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sh800000, 1'b1);
        send_sample(24'sh000000, 1'b0);
        send_sample(24'shFFFFFF, 1'b1);
        drain();

        // directed: zero period, full gains above hundred, short delay
        write_reg(chorus_pkg::REG_PERIOD, 0);
        write_reg(chorus_pkg::REG_DELAY, 1);
        write_reg(chorus_pkg::REG_DEPTH, 4095);
        write_reg(chorus_pkg::REG_DRY, 127);
        write_reg(chorus_pkg::REG_WET, 127);
        write_reg(chorus_pkg::REG_FEEDBACK, 127);
        write_reg(chorus_pkg::REG_POLARITY, 0);
        write_reg(8'd8, 20'hFFFFF);
        for (int i = 0; i < 6; i++)
        begin
            send_sample(i % 2 ? 24'sh7FFFFF : 24'sh800000, i[0]);
        end
        drain();

        // directed: period of one, sine, both subtract, widest offsets
        write_reg(chorus_pkg::REG_PERIOD, 1);
        write_reg(chorus_pkg::REG_POLARITY, 3);
        write_reg(chorus_pkg::REG_DELAY, 4095);
        for (int i = 0; i < 4; i++) send_sample(pick_sample(), 1'b0);
        drain();
        write_reg(chorus_pkg::REG_WAVE, 1);
        write_reg(chorus_pkg::REG_PERIOD, 2);
        write_reg(chorus_pkg::REG_DRY, 0);
        write_reg(chorus_pkg::REG_WET, 100);
        write_reg(chorus_pkg::REG_FEEDBACK, 0);
        write_reg(chorus_pkg::REG_POLARITY, 2);
        for (int i = 0; i < 6; i++) send_sample(pick_sample(), 1'b1);
        drain();

        // random phases with fresh settings each time
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (int ph = 0; ph < 12; ph++)
        begin
            random_settings();
            if (i_checker.use_sine) sine_phases++;
            sender_idles   = (ph % 4 != 1);
            receiver_idles = (ph % 4 != 1);
            if (ph == 3)
            begin
                // fill the block while the receiver holds off
                sender_idles  = 1'b0;
                long_hold_req = 1'b1;
            end
            for (int i = 0; i < 100; i++)
            begin
                send_sample(pick_sample(), ($urandom_range(0, 15) == 0));
            end
            drain();
        end

        $display("run covered %0d samples, %0d results, %0d register writes, %0d sine phases",
                 samples_sent, results_seen, reg_writes, sine_phases);
        if (errors == 0 && pending == 0)
        begin
            $display("[lfo_modulated_delay_chorus_unit] OK");
        end
        else
        begin
            $display("[lfo_modulated_delay_chorus_unit] ERROR");
        end
        $finish;
    end

endmodule
